@@ src/rtkss_pkg.sv @@
package rtkss_pkg;

    localparam int MAX_KEEP       = 64;
    localparam int KEEP_W         = $clog2(MAX_KEEP + 1);
    localparam int ROW_INDEX_BITS = 16;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 16;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [POS_W-1:0]          POS_NONE  = {POS_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      row_end;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] chosen_value;
        logic [POS_W-1:0]          chosen_position;
        logic                      position_valid;
        logic                      final_result;
    } out_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic                      filled;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ src/rtkss_cell.sv @@
module rtkss_cell
    import rtkss_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cell_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic [POS_W-1:0]          new_position,
    input  entry_t                    prev_entry,
    input  logic                      prev_gt,
    input  entry_t                    next_entry,
    output entry_t                    entry,
    output logic                      gt
);

    entry_t ent_reg;
    entry_t ent_next;

    // unfilled slots rank above any value
    assign gt    = !ent_reg.filled || (ent_reg.value > new_value);
    assign entry = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.insert && gt) begin
            if (prev_gt) begin
                ent_next = prev_entry;
            end else begin
                ent_next.value    = new_value;
                ent_next.position = new_position;
                ent_next.filled   = 1'b1;
            end
        end else if (ctrl.shift) begin
            ent_next = next_entry;
        end
        if (ctrl.clear) begin
            ent_next.filled = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.filled <= 1'b0;
        end else begin
            ent_reg.filled <= ent_next.filled;
        end
        ent_reg.value    <= ent_next.value;
        ent_reg.position <= ent_next.position;
    end

endmodule

@@ src/row_top_k_smallest_select_top.sv @@
// Keeps the k smallest values of a row (k = keep_count, 0 taken as 1, above 64 taken
// as 64) in a sorted chain of 64 compare-and-shift cells, ties keeping the earlier
// element first. One element is taken per cycle while the row streams in. The element
// marked row_end is inserted, then k results leave in ascending order, one per cycle
// as the sink allows; s_ready is low while they leave. Slots the row never filled come
// out as 0x7FFFFFFF with position 0xFFFF and position_valid low. Positions count from 0
// and wrap at 2^16. keep_count is read at the end of each row.
module row_top_k_smallest_select_top
    import rtkss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEEP_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [KEEP_W-1:0]         keep_count_reg;
    logic [KEEP_W-1:0]         k_reg, k_next;
    logic [KEEP_W-1:0]         emit_cnt_reg, emit_cnt_next;
    logic [ROW_INDEX_BITS-1:0] elem_cnt_reg, elem_cnt_next;
    logic [KEEP_W-1:0]         k_clamped;

    logic       s_xfer;
    logic       m_xfer;
    logic       last_out;
    cell_ctrl_t ctrl;

    entry_t entries [MAX_KEEP];
    logic   gts     [MAX_KEEP];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_RUN);
    assign m_valid   = (state_reg == ST_EMIT);
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid && m_ready;
    assign last_out  = (KEEP_W'(emit_cnt_reg + 1'b1) == k_reg);

    assign ctrl.insert = s_xfer;
    assign ctrl.shift  = m_xfer;
    assign ctrl.clear  = m_xfer && last_out;

    always_comb begin
        if (keep_count_reg == '0) begin
            k_clamped = KEEP_W'(1);
        end else if (keep_count_reg > KEEP_W'(MAX_KEEP)) begin
            k_clamped = KEEP_W'(MAX_KEEP);
        end else begin
            k_clamped = keep_count_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_KEEP; i++) begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_g;
            if (i == 0) begin : g_head
                assign prev_e = '0;
                assign prev_g = 1'b0;
            end else begin : g_mid
                assign prev_e = entries[i-1];
                assign prev_g = gts[i-1];
            end
            if (i == MAX_KEEP - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_body
                assign next_e = entries[i+1];
            end
            rtkss_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (ctrl),
                .new_value    (s_data.sample_value),
                .new_position (POS_W'(elem_cnt_reg)),
                .prev_entry   (prev_e),
                .prev_gt      (prev_g),
                .next_entry   (next_e),
                .entry        (entries[i]),
                .gt           (gts[i])
            );
        end
    endgenerate

    always_comb begin
        m_data.final_result = last_out;
        if (entries[0].filled) begin
            m_data.chosen_value    = entries[0].value;
            m_data.chosen_position = entries[0].position;
            m_data.position_valid  = 1'b1;
        end else begin
            m_data.chosen_value    = VALUE_MAX;
            m_data.chosen_position = POS_NONE;
            m_data.position_valid  = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        emit_cnt_next = emit_cnt_reg;
        elem_cnt_next = elem_cnt_reg;
        case (state_reg)
            ST_RUN: begin
                if (s_xfer) begin
                    if (s_data.row_end) begin
                        elem_cnt_next = '0;
                        k_next        = k_clamped;
                        emit_cnt_next = '0;
                        state_next    = ST_EMIT;
                    end else begin
                        elem_cnt_next = ROW_INDEX_BITS'(elem_cnt_reg + 1'b1);
                    end
                end
            end
            ST_EMIT: begin
                if (m_xfer) begin
                    emit_cnt_next = KEEP_W'(emit_cnt_reg + 1'b1);
                    if (last_out) begin
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            keep_count_reg <= KEEP_W'(1);
            elem_cnt_reg   <= '0;
            emit_cnt_reg   <= '0;
            k_reg          <= KEEP_W'(1);
        end else begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            k_reg        <= k_next;
            if (cfg_valid && cfg_ready) begin
                keep_count_reg <= cfg_data;
            end
        end
    end

endmodule
